// File: rtl/prf_pkg.sv
// shared types, constants and helpers for the page replacement block
// no dependencies; imported by every other file in rtl/ except prf_frame_mem

package prf_pkg;

    // defaults for the top level parameters
    localparam int MAX_FRAMES_DEF = 512;
    localparam int PAGE_SHIFT_DEF = 12;   // 4096-byte pages

    // fixed field widths
    localparam int ADDR_W   = 32;
    localparam int CNT_W    = 32;
    localparam int VICTIM_W = 20;
    localparam int FC_W     = 10;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [FC_W-1:0] FC_RESET = FC_W'(64);

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_POLICY      = 1'b1;

    // policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic [FC_W-1:0] frame_count;
        logic            policy;
    } t_cfg;

    typedef struct packed {
        logic                hit;
        logic                evicted;
        logic [VICTIM_W-1:0] victim_page;
        logic [CNT_W-1:0]    hit_total;
        logic [CNT_W-1:0]    miss_total;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

// File: rtl/prf_apb_regs.sv
// configuration registers behind an apb-style slave port
// depends on prf_pkg

module prf_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prf_pkg::APB_AW-1:0]  paddr,
    input  logic [prf_pkg::APB_DW-1:0]  pwdata,
    output logic [prf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output prf_pkg::t_cfg               o_cfg
);
    import prf_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_count <= FC_RESET;
            r_cfg.policy      <= POLICY_FIFO;
        end else if (wr_en) begin
            case (paddr[2])
                REG_FRAME_COUNT: r_cfg.frame_count <= pwdata[FC_W-1:0];
                REG_POLICY:      r_cfg.policy      <= pwdata[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FRAME_COUNT: prdata = APB_DW'(r_cfg.frame_count);
            REG_POLICY:      prdata = APB_DW'(r_cfg.policy);
            default:         prdata = '0;
        endcase
    end

endmodule

// File: rtl/prf_frame_mem.sv
// frame table storage: page number and stamp per frame
// one write port, one read port with registered read data; no dependencies

module prf_frame_mem #(
    parameter int  DEPTH  = 512,
    parameter int  WIDTH  = 52,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: rtl/prf_engine.sv
// lookup and replacement sequencer: scans the frame table, picks hit or victim,
// writes back and keeps the counters; depends on prf_pkg, drives prf_frame_mem

module prf_engine #(
    parameter int  MAX_FRAMES = prf_pkg::MAX_FRAMES_DEF,
    parameter int  PAGE_SHIFT = prf_pkg::PAGE_SHIFT_DEF,
    localparam int IDX_W      = $clog2(MAX_FRAMES),
    localparam int ENT_W      = prf_pkg::ADDR_W - PAGE_SHIFT + prf_pkg::CNT_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prf_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [prf_pkg::ADDR_W-1:0]  i_byte_address,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output prf_pkg::t_result            o_res,
    output logic                        o_rd_en,
    output logic [IDX_W-1:0]            o_rd_addr,
    input  logic [ENT_W-1:0]            i_rd_data,
    output logic                        o_wr_en,
    output logic [IDX_W-1:0]            o_wr_addr,
    output logic [ENT_W-1:0]            o_wr_data
);
    import prf_pkg::*;

    localparam int PAGE_W = ADDR_W - PAGE_SHIFT;
    localparam int FU_W   = $clog2(MAX_FRAMES + 1);
    localparam int CW     = (FU_W > FC_W) ? FU_W : FC_W;

    t_state              r_state, n_state;
    logic [PAGE_W-1:0]   r_page;
    logic [FU_W-1:0]     r_rd_idx, n_rd_idx;
    logic [FU_W-1:0]     r_frames_used, n_frames_used;
    logic [CNT_W-1:0]    r_use_clock, n_use_clock;
    logic [CNT_W-1:0]    r_hit_cnt, n_hit_cnt;
    logic [CNT_W-1:0]    r_miss_cnt, n_miss_cnt;

    // scan pipeline: read issue, compare, select
    logic                r_d1_vld;
    logic [IDX_W-1:0]    r_d1_idx;
    logic                r_d2_vld;
    logic [IDX_W-1:0]    r_d2_idx;
    logic                r_d2_match;
    logic [CNT_W-1:0]    r_d2_age;
    logic [PAGE_W-1:0]   r_d2_page;

    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_hit_idx, n_hit_idx;
    logic                r_have, n_have;
    logic [CNT_W-1:0]    r_best_age, n_best_age;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [PAGE_W-1:0]   r_best_page, n_best_page;

    logic                issue;
    logic                advance;
    logic                full;
    logic [CW-1:0]       fc_ext, cap;
    logic [PAGE_W-1:0]   rd_page;
    logic [CNT_W-1:0]    rd_stamp;

    assign rd_page  = i_rd_data[ENT_W-1:CNT_W];
    assign rd_stamp = i_rd_data[CNT_W-1:0];

    // frame count clamped to 1..MAX_FRAMES
    always_comb begin
        fc_ext = CW'(i_cfg.frame_count);
        if (fc_ext == '0) begin
            cap = CW'(1);
        end else if (fc_ext > CW'(MAX_FRAMES)) begin
            cap = CW'(MAX_FRAMES);
        end else begin
            cap = fc_ext;
        end
    end

    assign full  = CW'(r_frames_used) >= cap;
    assign issue = (r_state == S_SCAN) && (r_rd_idx < r_frames_used);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_WRITE);
    assign advance     = o_res_valid && i_res_ready;
    assign o_rd_en     = issue;
    assign o_rd_addr   = r_rd_idx[IDX_W-1:0];

    always_comb begin
        n_state       = r_state;
        n_rd_idx      = r_rd_idx;
        n_frames_used = r_frames_used;
        n_use_clock   = r_use_clock;
        n_hit_cnt     = r_hit_cnt;
        n_miss_cnt    = r_miss_cnt;
        n_found       = r_found;
        n_hit_idx     = r_hit_idx;
        n_have        = r_have;
        n_best_age    = r_best_age;
        n_best_idx    = r_best_idx;
        n_best_page   = r_best_page;
        o_wr_en       = 1'b0;
        o_wr_addr     = r_hit_idx;
        o_wr_data     = {r_page, r_use_clock};
        o_res         = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state  = S_SCAN;
                    n_rd_idx = '0;
                    n_found  = 1'b0;
                    n_have   = 1'b0;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + FU_W'(1);
                end
                if (r_d2_vld) begin
                    if (r_d2_match && !r_found) begin
                        n_found   = 1'b1;
                        n_hit_idx = r_d2_idx;
                    end
                    // strict compare keeps the lowest index on equal ages
                    if (!r_have || (r_d2_age > r_best_age)) begin
                        n_have      = 1'b1;
                        n_best_age  = r_d2_age;
                        n_best_idx  = r_d2_idx;
                        n_best_page = r_d2_page;
                    end
                end
                if (!issue && !r_d1_vld && !r_d2_vld) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_res.hit_total  = r_hit_cnt;
                o_res.miss_total = r_miss_cnt;
                if (r_found) begin
                    o_res.hit       = 1'b1;
                    o_res.hit_total = sat_inc(r_hit_cnt);
                    o_wr_en         = advance && (i_cfg.policy == POLICY_LRU);
                    o_wr_addr       = r_hit_idx;
                end else begin
                    o_res.miss_total = sat_inc(r_miss_cnt);
                    o_wr_en          = advance;
                    if (full) begin
                        o_res.evicted     = 1'b1;
                        o_res.victim_page = VICTIM_W'(r_best_page);
                        o_wr_addr         = r_best_idx;
                    end else begin
                        o_wr_addr = r_frames_used[IDX_W-1:0];
                    end
                end
                if (advance) begin
                    n_state     = S_IDLE;
                    n_hit_cnt   = o_res.hit_total;
                    n_miss_cnt  = o_res.miss_total;
                    n_use_clock = r_use_clock + CNT_W'(1);
                    if (!r_found && !full) begin
                        n_frames_used = r_frames_used + FU_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frames_used <= '0;
            r_use_clock   <= '0;
            r_hit_cnt     <= '0;
            r_miss_cnt    <= '0;
            r_d1_vld      <= 1'b0;
            r_d2_vld      <= 1'b0;
            r_found       <= 1'b0;
            r_have        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_frames_used <= n_frames_used;
            r_use_clock   <= n_use_clock;
            r_hit_cnt     <= n_hit_cnt;
            r_miss_cnt    <= n_miss_cnt;
            r_d1_vld      <= issue;
            r_d2_vld      <= r_d1_vld;
            r_found       <= n_found;
            r_have        <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_page <= i_byte_address[ADDR_W-1:PAGE_SHIFT];
        end
        r_rd_idx    <= n_rd_idx;
        r_d1_idx    <= r_rd_idx[IDX_W-1:0];
        r_d2_idx    <= r_d1_idx;
        r_d2_match  <= (rd_page == r_page);
        r_d2_age    <= r_use_clock - rd_stamp;
        r_d2_page   <= rd_page;
        r_hit_idx   <= n_hit_idx;
        r_best_age  <= n_best_age;
        r_best_idx  <= n_best_idx;
        r_best_page <= n_best_page;
    end

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames_used <= FU_W'(MAX_FRAMES))
        else $error("frames in use beyond table depth");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_d1_vld && !r_d2_vld))
        else $error("scan pipeline busy while idle");

    a_evict_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && o_res.evicted) |=> $stable(r_frames_used))
        else $error("occupancy changed on an eviction");

    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_hit_cnt != $past(r_hit_cnt)) + (r_miss_cnt != $past(r_miss_cnt))
                    <= 2'd1)
        else $error("both counters moved on one word");
`endif

endmodule

// File: rtl/page_replacement_fifo_lru.sv
// page replacement block: takes one byte address per word and returns one
// result word with hit/evict status, victim page and running totals. Each word
// is served by a scan of the frame table memory, one frame read per cycle
// through its single read port, over the frames in use only; a new word is
// accepted only after the current one is written back, and a finished word
// waits while the output register is still held by the result side. Frames
// fill in index order and never empty, so occupancy is tracked by a fill count
// and there is no clearing pass after reset. Configuration is written over the
// apb-style port at byte address 0 (frame_count) and 4 (policy, 0 fifo, 1 lru);
// the user must write it only while idle, which the block does not enforce.
// depends on prf_pkg, prf_apb_regs, prf_frame_mem, prf_engine

module page_replacement_fifo_lru #(
    parameter int MAX_FRAMES = prf_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_SHIFT = prf_pkg::PAGE_SHIFT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prf_pkg::APB_AW-1:0]    paddr,
    input  logic [prf_pkg::APB_DW-1:0]    pwdata,
    output logic [prf_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    // address words in
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [prf_pkg::ADDR_W-1:0]    i_byte_address,
    // result words out
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic                          o_evicted,
    output logic [prf_pkg::VICTIM_W-1:0]  o_victim_page,
    output logic [prf_pkg::CNT_W-1:0]     o_hit_total,
    output logic [prf_pkg::CNT_W-1:0]     o_miss_total
);
    import prf_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int ENT_W = ADDR_W - PAGE_SHIFT + CNT_W;   // page number + stamp

    t_cfg              cfg;
    t_result           res;
    logic              res_valid;
    logic              res_ready;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [ENT_W-1:0]  rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;

    // output register: holds a finished word while the next one is scanned
    logic              r_out_valid;
    t_result           r_out;

    prf_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    prf_frame_mem #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (ENT_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    prf_engine #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_byte_address (i_byte_address),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data)
    );

    // the engine commits a word only when the output register can take it
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out.hit;
    assign o_evicted     = r_out.evicted;
    assign o_victim_page = r_out.victim_page;
    assign o_hit_total   = r_out.hit_total;
    assign o_miss_total  = r_out.miss_total;

endmodule
